[hdl/plfm_pkg.sv]
`default_nettype none
package plfm_pkg;

	localparam int ID_W = 48;
	localparam int QTY_W = 16;
	localparam int KIND_W = 2;
	localparam int QUEUE_DEPTH_DEF = 32;

	localparam logic [KIND_W-1:0] KIND_RESTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TAKER  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

	typedef struct packed {
		logic             side;
		logic [QTY_W-1:0] quantity;
	} order_t;

	typedef struct packed {
		logic [KIND_W-1:0] record_kind;
		logic [ID_W-1:0]   order_id;
		logic              order_side;
		logic [QTY_W-1:0]  fill_quantity;
		logic              last;
	} record_t;

	// controller -> datapath
	typedef struct packed {
		logic take_in;
		logic fill_step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic opposite;
		logic fill_last;
	} sts_t;

endpackage
`default_nettype wire

[hdl/plfm_ctrl.sv]
`default_nettype none
module plfm_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         order_valid,
	output logic              order_ready,
	input  wire plfm_pkg::sts_t sts,
	output plfm_pkg::cmd_t    cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_MATCH = 1'b1;

	logic state_q;
	logic state_d;

	assign order_ready   = (state_q == ST_IDLE) && sts.out_free;
	assign cmd.take_in   = order_valid && order_ready;
	assign cmd.fill_step = (state_q == ST_MATCH) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take_in && sts.opposite) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (cmd.fill_step && sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/plfm_dpath.sv]
`default_nettype none
module plfm_dpath #(
	parameter int QUEUE_DEPTH = plfm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire plfm_pkg::order_t order,
	input  wire plfm_pkg::cmd_t   cmd,
	output plfm_pkg::sts_t        sts,
	output logic                  record_valid,
	input  wire logic             record_ready,
	output plfm_pkg::record_t     record
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int ID_W  = plfm_pkg::ID_W;
	localparam int QTY_W = plfm_pkg::QTY_W;

	logic [ID_W-1:0]  id_mem  [QUEUE_DEPTH];
	logic [QTY_W-1:0] qty_mem [QUEUE_DEPTH];

	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             book_side_q, book_side_d;
	logic [ID_W-1:0]  next_id_q;
	logic [ID_W-1:0]  new_id;
	logic [QTY_W-1:0] remaining_q;
	logic [ID_W-1:0]  taker_id_q;
	logic             taker_side_q;
	logic [ID_W-1:0]  rd_id_q;
	logic [QTY_W-1:0] rd_qty_q;

	logic             record_valid_q;
	plfm_pkg::record_t record_q, record_d;

	logic             id_we, qty_we;
	logic [PTR_W-1:0] wr_addr;
	logic [ID_W-1:0]  wr_id;
	logic [QTY_W-1:0] wr_qty;

	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head_inc;
	logic             same_side;
	logic             book_full;

	logic             full_take;
	logic [QTY_W-1:0] fill_qty;
	logic [QTY_W-1:0] rem_new;
	logic [CNT_W-1:0] cnt_new;
	logic             fill_last;

	assign new_id    = next_id_q + ID_W'(1);
	assign same_side = (count_q == '0) || (book_side_q == order.side);
	assign book_full = (count_q == CNT_W'(QUEUE_DEPTH));

	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// one fill against the front order, using the registered read data
	assign full_take = (rd_qty_q <= remaining_q);
	assign fill_qty  = full_take ? rd_qty_q : remaining_q;
	assign rem_new   = full_take ? (remaining_q - rd_qty_q) : '0;
	assign cnt_new   = full_take ? (count_q - CNT_W'(1)) : count_q;
	assign fill_last = !full_take || (rem_new == '0) || (cnt_new == '0);

	assign sts.out_free  = !record_valid_q || record_ready;
	assign sts.opposite  = !same_side && (order.quantity != '0);
	assign sts.fill_last = fill_last;

	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		book_side_d = book_side_q;
		id_we       = 1'b0;
		qty_we      = 1'b0;
		wr_addr     = tail;
		wr_id       = new_id;
		wr_qty      = order.quantity;
		record_d    = record_q;
		if (cmd.take_in) begin
			record_d.order_id      = new_id;
			record_d.order_side    = order.side;
			record_d.fill_quantity = order.quantity;
			if (same_side) begin
				record_d.last = 1'b1;
				if (book_full) begin
					record_d.record_kind = plfm_pkg::KIND_REJECT;
				end else begin
					record_d.record_kind = plfm_pkg::KIND_RESTED;
					if (count_q == '0) begin
						book_side_d = order.side;
					end
					id_we   = 1'b1;
					qty_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end else begin
				record_d.record_kind = plfm_pkg::KIND_TAKER;
				record_d.last        = (order.quantity == '0);
			end
		end else if (cmd.fill_step) begin
			record_d.record_kind   = plfm_pkg::KIND_FILL;
			record_d.order_id      = rd_id_q;
			record_d.order_side    = book_side_q;
			record_d.fill_quantity = fill_qty;
			record_d.last          = fill_last;
			count_d                = cnt_new;
			if (full_take) begin
				head_d = (cnt_new == '0) ? '0 : head_inc;
				if ((cnt_new == '0) && (rem_new != '0)) begin
					// taker remainder rests alone in slot zero
					book_side_d = taker_side_q;
					id_we       = 1'b1;
					qty_we      = 1'b1;
					wr_addr     = '0;
					wr_id       = taker_id_q;
					wr_qty      = rem_new;
					count_d     = CNT_W'(1);
				end
			end else begin
				qty_we  = 1'b1;
				wr_addr = head_q;
				wr_qty  = rd_qty_q - remaining_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[wr_addr] <= wr_id;
		end
		rd_id_q <= id_mem[head_d];
	end

	always_ff @(posedge clk) begin
		if (qty_we) begin
			qty_mem[wr_addr] <= wr_qty;
		end
		rd_qty_q <= qty_mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			book_side_q    <= 1'b0;
			next_id_q      <= '0;
			record_valid_q <= 1'b0;
		end else begin
			head_q      <= head_d;
			count_q     <= count_d;
			book_side_q <= book_side_d;
			if (cmd.take_in) begin
				next_id_q <= new_id;
			end
			if (cmd.take_in || cmd.fill_step) begin
				record_valid_q <= 1'b1;
			end else if (record_ready) begin
				record_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		record_q <= record_d;
		if (cmd.take_in) begin
			remaining_q  <= order.quantity;
			taker_id_q   <= new_id;
			taker_side_q <= order.side;
		end else if (cmd.fill_step) begin
			remaining_q <= rem_new;
		end
	end

	assign record_valid = record_valid_q;
	assign record       = record_q;

endmodule
`default_nettype wire

[hdl/price_level_fifo_matcher.sv]
// One price level of an order book with time priority.
// Order channel (order_valid/order_ready/order): side and quantity of a new
// order. Every accepted item takes the next 48-bit id.
// Record channel (record_valid/record_ready/record): rested, rejected, taker
// and fill records; last marks the final record caused by an order.
// The first record of an order is valid in the cycle after accept.
// Same side or empty book: one record, next order taken as soon as that
// record leaves the output register (one item per cycle when not stalled).
// Opposite side: taker record, then one fill per book order it reaches, the
// last possibly partial, one fill per cycle when not stalled, paced by the
// registered read of the queue memory; a zero-quantity order gives no fills.
// A stalled receiver holds the output register; the block waits and loses
// nothing. Reset empties the book, sets the book side to sell and restarts
// ids at 1; queue memory contents are not cleared.
`default_nettype none
module price_level_fifo_matcher #(
	parameter int QUEUE_DEPTH = plfm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             order_valid,
	output logic                  order_ready,
	input  wire plfm_pkg::order_t order,
	output logic                  record_valid,
	input  wire logic             record_ready,
	output plfm_pkg::record_t     record
);

	plfm_pkg::cmd_t cmd;
	plfm_pkg::sts_t sts;

	plfm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.order_valid (order_valid),
		.order_ready (order_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	plfm_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.order        (order),
		.cmd          (cmd),
		.sts          (sts),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take_in && cmd.fill_step))
		else $error("accept and fill in the same cycle");

	a_rec_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_in || cmd.fill_step) |=> record_valid)
		else $error("record not loaded");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_in && !sts.opposite) |=> record.last)
		else $error("single-record item without last");

	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_step && sts.fill_last) |=> record.last)
		else $error("final fill record wrong");

endmodule
`default_nettype wire

[dv/price_level_fifo_matcher_tb.sv]
`default_nettype none
module price_level_fifo_matcher_tb;

	localparam int DEPTH = plfm_pkg::QUEUE_DEPTH_DEF;
	localparam int ID_W = plfm_pkg::ID_W;
	localparam int QTY_W = plfm_pkg::QTY_W;
	localparam int KIND_W = plfm_pkg::KIND_W;
	localparam int RANDOM_ORDERS = 350;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [ID_W-1:0]  id;
		logic [QTY_W-1:0] qty;
	} resting_t;

	logic              clk;
	logic              arst_n;
	logic              order_valid;
	logic              order_ready;
	plfm_pkg::order_t  order;
	logic              record_valid;
	logic              record_ready;
	plfm_pkg::record_t record;

	// shadow of the price level
	resting_t          resting_orders[$];
	logic              resting_side;
	logic [ID_W-1:0]   last_order_id;
	plfm_pkg::record_t pending_records[$];

	int  error_count;
	int  cycle_count;
	int  hold_left;
	bit  send_gaps;
	bit  recv_gaps;
	plfm_pkg::record_t seen_want;

	price_level_fifo_matcher #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.order_valid (order_valid),
		.order_ready (order_ready),
		.order       (order),
		.record_valid(record_valid),
		.record_ready(record_ready),
		.record      (record)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void push_record(logic [KIND_W-1:0] kind,
			logic [ID_W-1:0] id, logic side, logic [QTY_W-1:0] qty, logic last);
		plfm_pkg::record_t r;
		r.record_kind = kind;
		r.order_id = id;
		r.order_side = side;
		r.fill_quantity = qty;
		r.last = last;
		pending_records.push_back(r);
	endfunction

	// Runs one accepted order against the shadow book and queues its records.
	function automatic void match_order(plfm_pkg::order_t o);
		logic [ID_W-1:0]   id;
		logic [QTY_W-1:0]  left;
		resting_t          head;
		plfm_pkg::record_t tail;
		last_order_id = last_order_id + 1'b1;
		id = last_order_id;
		if (resting_orders.size() == 0 || resting_side == o.side) begin
			if (resting_orders.size() >= DEPTH) begin
				push_record(plfm_pkg::KIND_REJECT, id, o.side, o.quantity, 1'b1);
				return;
			end
			if (resting_orders.size() == 0)
				resting_side = o.side;
			resting_orders.push_back('{id, o.quantity});
			push_record(plfm_pkg::KIND_RESTED, id, o.side, o.quantity, 1'b1);
			return;
		end
		push_record(plfm_pkg::KIND_TAKER, id, o.side, o.quantity, 1'b0);
		left = o.quantity;
		while (left > 0 && resting_orders.size() > 0) begin
			head = resting_orders[0];
			if (head.qty <= left) begin
				push_record(plfm_pkg::KIND_FILL, head.id, resting_side, head.qty, 1'b0);
				left = left - head.qty;
				void'(resting_orders.pop_front());
			end else begin
				push_record(plfm_pkg::KIND_FILL, head.id, resting_side, left, 1'b0);
				resting_orders[0].qty = head.qty - left;
				left = '0;
			end
		end
		if (left > 0) begin
			resting_side = o.side;
			resting_orders.push_back('{id, left});
		end
		tail = pending_records.pop_back();
		tail.last = 1'b1;
		pending_records.push_back(tail);
	endfunction

	function automatic void report_error(string what, plfm_pkg::record_t want,
			plfm_pkg::record_t got);
		error_count++;
		if (error_count <= 10) begin
			$write("%0t %s: want kind %0d id %h side %0d qty %h last %0d, ",
				$time, what, want.record_kind, want.order_id, want.order_side,
				want.fill_quantity, want.last);
			$display("got kind %0d id %h side %0d qty %h last %0d",
				got.record_kind, got.order_id, got.order_side,
				got.fill_quantity, got.last);
		end
	endfunction

	// Offer one order from a falling edge; predict at the accepting edge.
	task automatic send_order(logic side, logic [QTY_W-1:0] qty);
		plfm_pkg::order_t o;
		o.side = side;
		o.quantity = qty;
		@(negedge clk);
		while (send_gaps && $urandom_range(99) < 32) begin
			order_valid <= 1'b0;
			@(negedge clk);
		end
		order_valid <= 1'b1;
		order <= o;
		@(posedge clk);
		while (!order_ready)
			@(posedge clk);
		match_order(o);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		order_valid <= 1'b0;
	endtask

	function automatic logic [QTY_W-1:0] pick_quantity();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return QTY_W'($urandom_range(16, 1));
		else if (r < 70)
			return QTY_W'($urandom_range(1000, 1));
		else if (r < 85)
			return QTY_W'($urandom_range(65535, 1));
		else if (r < 95)
			case ($urandom_range(3))
				0: return 16'h0001;
				1: return 16'hffff;
				2: return 16'h8000;
				default: return 16'h7fff;
			endcase
		else if (r < 98)
			return QTY_W'($urandom);
		return '0;
	endfunction

	// Sweeps the book exactly; a lone zero-lot level is cleared through a 1-lot swap.
	task automatic drain_book();
		int total;
		while (resting_orders.size() > 0) begin
			total = 0;
			foreach (resting_orders[i])
				total += resting_orders[i].qty;
			if (total > 65535)
				total = 65535;
			if (total == 0)
				total = 1;
			send_order(~resting_side, QTY_W'(total));
		end
	endtask

	task automatic test_rest_and_take();
		send_order(1'b1, 16'd1);        // rests on the empty level as a buy
		send_order(1'b0, 16'hffff);     // takes it, remainder rests as sell
		send_order(1'b1, 16'hffff);     // sweeps the remainder, 1 lot rests
		send_order(1'b0, 16'd1);        // exact fill, level empty again
		send_order(1'b1, 16'd5);
		send_order(1'b0, 16'd3);        // partial fill of the front order
		send_order(1'b0, 16'd2);
		stop_sending();
	endtask

	task automatic test_zero_lot();
		drain_book();
		send_order(1'b0, 16'd0);        // zero-lot order rests
		send_order(1'b0, 16'd0);
		send_order(1'b0, 16'd7);
		send_order(1'b1, 16'd3);        // two 0-lot fills, then a partial
		send_order(1'b1, 16'd0);        // opposite zero: taker record only
		send_order(1'b1, 16'd4);
		send_order(1'b1, 16'd0);        // rests on an empty level
		send_order(1'b0, 16'd1);        // removes it with a 0-lot fill
		stop_sending();
	endtask

	task automatic test_book_full();
		logic side;
		drain_book();
		side = 1'($urandom_range(1));
		while (resting_orders.size() < DEPTH)
			send_order(side, QTY_W'($urandom_range(50, 1)));
		repeat (3)
			send_order(side, pick_quantity());
		// one taker plus a fill for every resting order
		send_order(~side, 16'hffff);
		stop_sending();
	endtask

	task automatic test_backpressure();
		logic side;
		hold_left = 400;
		side = 1'($urandom_range(1));
		repeat (40) begin
			if ($urandom_range(99) < 25)
				side = ~side;
			send_order(side, pick_quantity());
		end
		stop_sending();
	endtask

	task automatic test_random_traffic();
		logic side;
		side = 1'($urandom_range(1));
		for (int n = 0; n < RANDOM_ORDERS; n++) begin
			// first stretch runs with both sides flat out
			send_gaps = (n >= 120);
			recv_gaps = (n >= 120);
			if ($urandom_range(99) < 35)
				side = ~side;
			send_order(side, pick_quantity());
		end
		stop_sending();
	endtask

	// receiver
	initial begin
		record_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				record_ready <= 1'b0;
			end else begin
				record_ready <= !(recv_gaps && $urandom_range(99) < 32);
			end
		end
	end

	// record checker
	always @(posedge clk) begin
		if (arst_n && record_valid && record_ready) begin
			if (pending_records.size() == 0) begin
				report_error("unexpected record", '0, record);
			end else begin
				seen_want = pending_records.pop_front();
				if (record !== seen_want)
					report_error("record mismatch", seen_want, record);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		order_valid = 1'b0;
		order = '0;
		error_count = 0;
		cycle_count = 0;
		hold_left = 0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		resting_side = 1'b0;
		last_order_id = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_rest_and_take();
		test_zero_lot();
		test_book_full();
		test_backpressure();
		test_random_traffic();

		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_records.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
